// ===== rtl/core/ptpr_pkg.sv =====
// Shared types and constants for the point-to-plane residual block.
// Holds the configuration register map, quaternion format and fixed-point helpers.
// No dependencies.
package ptpr_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned QuatW    = 32;   // Q1.30 in a 32-bit register
  localparam int unsigned RotW     = 34;   // rotation matrix entry, Q.30
  localparam int unsigned NormBits = 30;   // fraction bits of the unit normal

  localparam logic signed [QuatW-1:0] QuatOne = 32'sd1073741824;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROT_X,
    CFG_ROT_Y,
    CFG_ROT_Z,
    CFG_ROT_W,
    CFG_SHIFT_X,
    CFG_SHIFT_Y,
    CFG_SHIFT_Z
  } cfg_idx_e;

  // limit a quaternion component to [-1, 1]
  function automatic logic signed [QuatW-1:0] quat_clamp(input logic signed [QuatW-1:0] v);
    logic signed [QuatW-1:0] r;
    r = v;
    if (v > QuatOne) begin
      r = QuatOne;
    end else if (v < -QuatOne) begin
      r = -QuatOne;
    end
    return r;
  endfunction

  // Q2.60 -> Q.30, round half up
  function automatic logic signed [RotW-1:0] round_q30(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = (v + (66'sd1 <<< 29)) >>> 30;
    return t[RotW-1:0];
  endfunction

endpackage

// ===== rtl/core/point_to_plane_residual.sv =====
// Top level of the point-to-plane residual pipeline.
// Depends on ptpr_pkg (register map, quaternion format, rounding helpers).
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one correspondence word per
//   cycle: point a and plane points b, c, d. Output channel (out_valid_o /
//   out_stall_i) returns the signed distance of R*a + t from the plane through
//   b, c, d, plus a degenerate flag when (d-b) x (c-b) is zero (residual 0).
//   Configuration port (cfg_valid_i / cfg_ready_o, always ready) writes the
//   pose: rot_x, rot_y, rot_z, rot_w, shift_x, shift_y, shift_z. Write it only
//   while no word is in flight; the rotation matrix settles through the product
//   and entry registers before any newly accepted word reaches the stage that
//   uses it. Throughput: one word per cycle while in_stall_o is low. The depth
//   is set by the bit-per-stage square root (31 stages) followed by the
//   bit-per-stage normal division (31 stages).
//   Reset clears the pipeline valids and the output/skid valid flags and loads
//   the identity pose. When the receiver stalls, the result is held; one more
//   finished word goes into a skid register, and only when that is full does
//   the whole pipeline freeze and raise in_stall_o.
module point_to_plane_residual #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ptpr_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ptpr_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]       a_x_i,
  input  logic signed [COORD_WIDTH-1:0]       a_y_i,
  input  logic signed [COORD_WIDTH-1:0]       a_z_i,
  input  logic signed [COORD_WIDTH-1:0]       b_x_i,
  input  logic signed [COORD_WIDTH-1:0]       b_y_i,
  input  logic signed [COORD_WIDTH-1:0]       b_z_i,
  input  logic signed [COORD_WIDTH-1:0]       c_x_i,
  input  logic signed [COORD_WIDTH-1:0]       c_y_i,
  input  logic signed [COORD_WIDTH-1:0]       c_z_i,
  input  logic signed [COORD_WIDTH-1:0]       d_x_i,
  input  logic signed [COORD_WIDTH-1:0]       d_y_i,
  input  logic signed [COORD_WIDTH-1:0]       d_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [COORD_WIDTH-1:0]       residual_o,
  output logic                                degenerate_o
);
  import ptpr_pkg::*;

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned EW   = W + 1;            // edge vector component
  localparam int unsigned PW   = 2 * EW;           // edge product
  localparam int unsigned CW   = PW + 1;           // cross component, signed
  localparam int unsigned MW   = PW;               // cross magnitude
  localparam int unsigned SW   = $clog2(MW + 1);   // reduction shift
  localparam int unsigned CMW  = NormBits;         // reduced magnitude
  localparam int unsigned SQW  = 2 * CMW;
  localparam int unsigned XW   = SQW + 2;          // sum of squares
  localparam int unsigned NSQ  = XW / 2;           // root bits, one per stage
  localparam int unsigned RTW  = NSQ;              // root / length width
  localparam int unsigned RMW  = RTW + 2;          // root remainder
  localparam int unsigned TrW  = RMW + 2;
  localparam int unsigned QTW  = CMW + 1;          // normal magnitude, <= 2^30
  localparam int unsigned NW   = QTW + 1;          // signed normal
  localparam int unsigned TW   = 32;               // translation register
  localparam int unsigned VW   = ((W > TW) ? W : TW) + 6;
  localparam int unsigned RAW  = W + RotW;
  localparam int unsigned RSW  = RAW + 2;
  localparam int unsigned DPW  = VW + NW;
  localparam int unsigned DSW  = DPW + 2;
  localparam int unsigned NS   = 7 + NSQ + QTW + 1; // pipeline stages

  localparam logic signed [DSW-1:0] ResMax = (DSW'(1) <<< (W - 1)) - DSW'(1);
  localparam logic signed [DSW-1:0] ResMin = -ResMax - DSW'(1);

  typedef struct packed {
    logic [2:0]          neg;
    logic                deg;
    logic [2:0][VW-1:0]  v;
  } side_t;

  // ---------------- configuration ----------------
  logic signed [QuatW-1:0] rot_x_q, rot_y_q, rot_z_q, rot_w_q;
  logic signed [TW-1:0]    shift_q [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_x_q    <= '0;
      rot_y_q    <= '0;
      rot_z_q    <= '0;
      rot_w_q    <= QuatOne;
      shift_q[0] <= '0;
      shift_q[1] <= '0;
      shift_q[2] <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ROT_X:   rot_x_q    <= cfg_data_i;
        CFG_ROT_Y:   rot_y_q    <= cfg_data_i;
        CFG_ROT_Z:   rot_z_q    <= cfg_data_i;
        CFG_ROT_W:   rot_w_q    <= cfg_data_i;
        CFG_SHIFT_X: shift_q[0] <= cfg_data_i;
        CFG_SHIFT_Y: shift_q[1] <= cfg_data_i;
        CFG_SHIFT_Z: shift_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Rotation matrix from the quaternion: products, then entries.
  logic signed [QuatW-1:0] qx, qy, qz, qw;
  logic signed [63:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic signed [RotW-1:0] rot_q [3][3];
  localparam logic signed [65:0] RotOne = 66'sd1 <<< 60;

  assign qx = quat_clamp(rot_x_q);
  assign qy = quat_clamp(rot_y_q);
  assign qz = quat_clamp(rot_z_q);
  assign qw = quat_clamp(rot_w_q);

  always_ff @(posedge clk_i) begin
    xx_q <= qx * qx;
    yy_q <= qy * qy;
    zz_q <= qz * qz;
    xy_q <= qx * qy;
    xz_q <= qx * qz;
    yz_q <= qy * qz;
    wx_q <= qw * qx;
    wy_q <= qw * qy;
    wz_q <= qw * qz;
  end

  always_ff @(posedge clk_i) begin
    rot_q[0][0] <= round_q30(RotOne - ((66'(yy_q) + 66'(zz_q)) <<< 1));
    rot_q[0][1] <= round_q30((66'(xy_q) - 66'(wz_q)) <<< 1);
    rot_q[0][2] <= round_q30((66'(xz_q) + 66'(wy_q)) <<< 1);
    rot_q[1][0] <= round_q30((66'(xy_q) + 66'(wz_q)) <<< 1);
    rot_q[1][1] <= round_q30(RotOne - ((66'(xx_q) + 66'(zz_q)) <<< 1));
    rot_q[1][2] <= round_q30((66'(yz_q) - 66'(wx_q)) <<< 1);
    rot_q[2][0] <= round_q30((66'(xz_q) - 66'(wy_q)) <<< 1);
    rot_q[2][1] <= round_q30((66'(yz_q) + 66'(wx_q)) <<< 1);
    rot_q[2][2] <= round_q30(RotOne - ((66'(xx_q) + 66'(yy_q)) <<< 1));
  end

  // ---------------- flow control ----------------
  logic          pipe_en;
  logic [NS-1:0] vld_q;
  logic          out_valid_q, skid_vld_q;
  logic          take;
  logic          res_new;

  assign pipe_en    = !skid_vld_q;
  assign in_stall_o = skid_vld_q;
  assign take       = out_valid_q && !out_stall_i;
  assign res_new    = pipe_en && vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  // ---------------- stage 1: edge vectors ----------------
  logic signed [W-1:0]  a_in [3], b_in [3], c_in [3], d_in [3];
  logic signed [EW-1:0] e1_q [3], e2_q [3];
  logic signed [W-1:0]  a1_q [3], b1_q [3];

  assign a_in = '{a_x_i, a_y_i, a_z_i};
  assign b_in = '{b_x_i, b_y_i, b_z_i};
  assign c_in = '{c_x_i, c_y_i, c_z_i};
  assign d_in = '{d_x_i, d_y_i, d_z_i};

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= EW'(d_in[i]) - EW'(b_in[i]);
        e2_q[i] <= EW'(c_in[i]) - EW'(b_in[i]);
        a1_q[i] <= a_in[i];
        b1_q[i] <= b_in[i];
      end
    end
  end

  // ---------------- stage 2: cross product terms ----------------
  logic signed [PW-1:0] xpa_q [3], xpb_q [3];
  logic signed [W-1:0]  a2_q [3], b2_q [3];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      xpa_q[0] <= e1_q[1] * e2_q[2];
      xpb_q[0] <= e1_q[2] * e2_q[1];
      xpa_q[1] <= e1_q[2] * e2_q[0];
      xpb_q[1] <= e1_q[0] * e2_q[2];
      xpa_q[2] <= e1_q[0] * e2_q[1];
      xpb_q[2] <= e1_q[1] * e2_q[0];
      a2_q     <= a1_q;
      b2_q     <= b1_q;
    end
  end

  // ---------------- stage 3: cross magnitude, R*a products ----------------
  logic signed [CW-1:0]  cr [3];
  logic [MW-1:0]         mag3_q [3];
  logic [2:0]            neg3_q;
  logic                  deg3_q;
  logic signed [RAW-1:0] ra3_q [3][3];
  logic signed [W-1:0]   b3_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i] = CW'(xpa_q[i]) - CW'(xpb_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        neg3_q[i] <= cr[i][CW-1];
        mag3_q[i] <= cr[i][CW-1] ? MW'(-cr[i]) : MW'(cr[i]);
        for (int j = 0; j < 3; j++) begin
          ra3_q[i][j] <= rot_q[i][j] * a2_q[j];
        end
      end
      deg3_q <= (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
      b3_q   <= b2_q;
    end
  end

  // ---------------- stage 4: reduction shift, v = R*a + t - b ----------------
  logic [MW-1:0]         orv;
  logic [SW-1:0]         blen, sh;
  logic signed [RSW-1:0] rsum [3], rrnd [3];
  logic [MW-1:0]         mag4_q [3];
  logic [SW-1:0]         sh4_q;
  side_t                 side4_d, side4_q;

  always_comb begin
    orv  = mag3_q[0] | mag3_q[1] | mag3_q[2];
    blen = '0;
    for (int i = 0; i < MW; i++) begin
      if (orv[i]) begin
        blen = SW'(i + 1);
      end
    end
    sh = (blen > SW'(CMW)) ? blen - SW'(CMW) : '0;
    side4_d.neg = neg3_q;
    side4_d.deg = deg3_q;
    for (int i = 0; i < 3; i++) begin
      rsum[i] = RSW'(ra3_q[i][0]) + RSW'(ra3_q[i][1]) + RSW'(ra3_q[i][2]);
      rrnd[i] = (rsum[i] + (RSW'(1) <<< 29)) >>> 30;
      side4_d.v[i] = rrnd[i][VW-1:0] + VW'(shift_q[i]) - VW'(b3_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      mag4_q  <= mag3_q;
      sh4_q   <= sh;
      side4_q <= side4_d;
    end
  end

  // ---------------- stage 5: reduced magnitudes ----------------
  logic [2:0][CMW-1:0] cm5_q;
  side_t               side5_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        cm5_q[i] <= CMW'(mag4_q[i] >> sh4_q);
      end
      side5_q <= side4_q;
    end
  end

  // ---------------- stage 6/7: sum of squares ----------------
  logic [SQW-1:0]      sq6_q [3];
  logic [2:0][CMW-1:0] cm6_q, cm7_q;
  side_t               side6_q, side7_q;
  logic [XW-1:0]       x7_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        sq6_q[i] <= SQW'(cm5_q[i]) * SQW'(cm5_q[i]);
      end
      cm6_q   <= cm5_q;
      side6_q <= side5_q;
      x7_q    <= XW'(sq6_q[0]) + XW'(sq6_q[1]) + XW'(sq6_q[2]);
      cm7_q   <= cm6_q;
      side7_q <= side6_q;
    end
  end

  // ---------------- square root, one root bit per stage ----------------
  logic [RMW-1:0]      sq_rem_q  [NSQ];
  logic [RTW-1:0]      sq_root_q [NSQ];
  logic [XW-1:0]       sq_x_q    [NSQ];
  logic [2:0][CMW-1:0] sq_cm_q   [NSQ];
  side_t               sq_side_q [NSQ];

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    localparam int unsigned Bit = NSQ - 1 - k;
    logic [RMW-1:0]      rem_in;
    logic [RTW-1:0]      root_in;
    logic [XW-1:0]       x_in;
    logic [2:0][CMW-1:0] cm_in;
    side_t               side_in;
    logic [TrW-1:0]      rem_n, trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x7_q;
      assign cm_in   = cm7_q;
      assign side_in = side7_q;
    end else begin : g_next
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign x_in    = sq_x_q[k-1];
      assign cm_in   = sq_cm_q[k-1];
      assign side_in = sq_side_q[k-1];
    end

    assign rem_n = {rem_in, x_in[2*Bit+1 -: 2]};
    assign trial = TrW'({root_in, 2'b01});

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        sq_x_q[k]    <= x_in;
        sq_cm_q[k]   <= cm_in;
        sq_side_q[k] <= side_in;
        if (rem_n >= trial) begin
          sq_rem_q[k]  <= RMW'(rem_n - trial);
          sq_root_q[k] <= {root_in[RTW-2:0], 1'b1};
        end else begin
          sq_rem_q[k]  <= rem_n[RMW-1:0];
          sq_root_q[k] <= {root_in[RTW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- normal division, one quotient bit per stage ----------------
  logic [2:0][RTW-1:0] dv_rem_q  [QTW];
  logic [2:0][QTW-1:0] dv_quo_q  [QTW];
  logic [RTW-1:0]      dv_len_q  [QTW];
  side_t               dv_side_q [QTW];

  for (genvar k = 0; k < QTW; k++) begin : g_div
    logic [2:0][RTW-1:0] rem_in;
    logic [2:0][QTW-1:0] quo_in;
    logic [RTW-1:0]      len_in;
    side_t               side_in;
    logic [2:0]          dbit;
    logic [2:0][RTW:0]   rem_n;

    if (k == 0) begin : g_first
      // dividend is cm << 30; all of cm enters here, the low bits that follow are zero
      for (genvar j = 0; j < 3; j++) begin : g_lane
        assign rem_in[j] = RTW'(sq_cm_q[NSQ-1][j][CMW-1:1]);
        assign dbit[j]   = sq_cm_q[NSQ-1][j][0];
      end
      assign quo_in  = '0;
      assign len_in  = sq_root_q[NSQ-1];
      assign side_in = sq_side_q[NSQ-1];
    end else begin : g_next
      assign rem_in  = dv_rem_q[k-1];
      assign quo_in  = dv_quo_q[k-1];
      assign len_in  = dv_len_q[k-1];
      assign side_in = dv_side_q[k-1];
      assign dbit    = '0;
    end

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        rem_n[j] = {rem_in[j], dbit[j]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        dv_len_q[k]  <= len_in;
        dv_side_q[k] <= side_in;
        for (int j = 0; j < 3; j++) begin
          if (rem_n[j] >= {1'b0, len_in}) begin
            dv_rem_q[k][j] <= RTW'(rem_n[j] - {1'b0, len_in});
            dv_quo_q[k][j] <= {quo_in[j][QTW-2:0], 1'b1};
          end else begin
            dv_rem_q[k][j] <= rem_n[j][RTW-1:0];
            dv_quo_q[k][j] <= {quo_in[j][QTW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // ---------------- dot product ----------------
  side_t                 dside;
  logic signed [NW-1:0]  nrm [3];
  logic signed [DPW-1:0] dp_q [3];
  logic                  dp_deg_q;

  assign dside = dv_side_q[QTW-1];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nrm[j] = dside.neg[j] ? -NW'(dv_quo_q[QTW-1][j]) : NW'(dv_quo_q[QTW-1][j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int j = 0; j < 3; j++) begin
        dp_q[j] <= $signed(dside.v[j]) * nrm[j];
      end
      dp_deg_q <= dside.deg;
    end
  end

  // final sum, round and saturate
  logic signed [DSW-1:0] dsum, drnd;
  logic signed [W-1:0]   res;

  always_comb begin
    dsum = DSW'(dp_q[0]) + DSW'(dp_q[1]) + DSW'(dp_q[2]);
    drnd = (dsum + (DSW'(1) <<< 29)) >>> 30;
    if (dp_deg_q) begin
      res = '0;
    end else if (drnd > ResMax) begin
      res = ResMax[W-1:0];
    end else if (drnd < ResMin) begin
      res = ResMin[W-1:0];
    end else begin
      res = drnd[W-1:0];
    end
  end

  // ---------------- output register and skid ----------------
  logic signed [W-1:0] res_q, skid_res_q;
  logic                deg_q, skid_deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_vld_q  <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (res_new) begin
      if (out_valid_q && !take) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        res_q <= skid_res_q;
        deg_q <= skid_deg_q;
      end
    end else if (res_new) begin
      if (out_valid_q && !take) begin
        skid_res_q <= res;
        skid_deg_q <= dp_deg_q;
      end else begin
        res_q <= res;
        deg_q <= dp_deg_q;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign residual_o   = res_q;
  assign degenerate_o = deg_q;

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_valid_q)
    else $error("skid word held without an output word");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid filled while output was free");

  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |-> (residual_o == '0))
    else $error("degenerate word with nonzero residual");

endmodule
